// File: sv/planar_vram_tile_raster_unit_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the planar VRAM tile raster unit
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PLANAR_VRAM_TILE_RASTER_UNIT_TOP_ASSERT_SVH
`define PLANAR_VRAM_TILE_RASTER_UNIT_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define PVTRU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pvtru assertion failed");
`define PVTRU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pvtru assertion failed");
`else
`define PVTRU_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define PVTRU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: sv/pvtru_pkg.sv
// ----------------------------------------------------------------------------
// pvtru_pkg
// Types, constants and helpers shared by the tile raster unit modules.
// ----------------------------------------------------------------------------
package pvtru_pkg;

    localparam int PLANE_BYTES = 32768;
    localparam int PAGE_COUNT  = 2;
    localparam int PLANE_COUNT = 4;

    localparam int OFF_W      = $clog2(PLANE_BYTES);
    localparam int HALF_AW    = OFF_W - 1;
    localparam int HALF_DEPTH = PLANE_BYTES / 2;
    localparam int BANK_DEPTH = PAGE_COUNT * HALF_DEPTH;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);

    localparam int OP_W       = 3;
    localparam int OFFSET_W   = 15;
    localparam int DATA_W     = 16;
    localparam int SHOWN_W    = 2;
    localparam int MASK_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [OP_W-1:0] OP_READ       = 3'd0;
    localparam logic [OP_W-1:0] OP_WRITE      = 3'd1;
    localparam logic [OP_W-1:0] OP_CMP_READ   = 3'd2;
    localparam logic [OP_W-1:0] OP_RMW        = 3'd3;
    localparam logic [OP_W-1:0] OP_TILE_WRITE = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_MASK   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_R = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_G = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_E = 3'd4;

    typedef logic [HALF_AW-1:0] t_half_addr;
    typedef logic [BANK_AW-1:0] t_bank_addr;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic clear;
        logic accept;
        logic fire;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
    } t_dp_status;

    function automatic t_bank_addr bank_addr(input logic pg, input t_half_addr half);
        return (t_bank_addr'(pg) << HALF_AW) | t_bank_addr'(half);
    endfunction

endpackage

// File: sv/pvtru_ctrl.sv
// ----------------------------------------------------------------------------
// pvtru_ctrl
// Sequencer for the dirty-mark clearing pass, the read and the write phase.
// ----------------------------------------------------------------------------
module pvtru_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output pvtru_pkg::t_dp_cmd     o_cmd,
    input  pvtru_pkg::t_dp_status  i_status
);
    import pvtru_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.fire = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_out_valid = o_cmd.fire | (r_out_valid & i_out_stall);
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: sv/pvtru_datapath.sv
// ----------------------------------------------------------------------------
// pvtru_datapath
// Plane banks split into even and odd bytes, tile logic, dirty marks,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
module pvtru_datapath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  pvtru_pkg::t_dp_cmd                    i_cmd,
    output pvtru_pkg::t_dp_status                 o_status,
    input  logic                                  i_cfg_wr_en,
    input  logic [pvtru_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [pvtru_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic [pvtru_pkg::OP_W-1:0]            i_operation,
    input  logic                                  i_word_access,
    input  logic                                  i_page,
    input  logic [1:0]                            i_plane,
    input  logic [pvtru_pkg::OFFSET_W-1:0]        i_offset,
    input  logic [pvtru_pkg::DATA_W-1:0]          i_write_data,
    output logic [pvtru_pkg::DATA_W-1:0]          o_read_data,
    output logic [pvtru_pkg::SHOWN_W-1:0]         o_graphics_shown
);
    import pvtru_pkg::*;

    logic [MASK_W-1:0]  r_mask;
    logic [7:0]         r_tile [PLANE_COUNT];
    logic [SHOWN_W-1:0] r_shown;
    logic [SHOWN_W-1:0] n_shown;
    t_half_addr         r_clr_addr;

    logic [OP_W-1:0]    r_op;
    logic               r_wide;
    logic               r_pg;
    logic [1:0]         r_plane;
    logic               r_par;
    t_half_addr         r_even_half;
    t_half_addr         r_odd_half;
    logic [DATA_W-1:0]  r_data;

    logic               pg_in;
    logic [OFF_W-1:0]   off0_in;
    t_half_addr         half0_in;
    t_half_addr         even_half_in;
    t_bank_addr         rd_addr_even;
    t_bank_addr         rd_addr_odd;
    t_bank_addr         wr_addr_even;
    t_bank_addr         wr_addr_odd;

    logic [7:0]         rd_even [PLANE_COUNT];
    logic [7:0]         rd_odd  [PLANE_COUNT];
    logic [7:0]         lo_b    [PLANE_COUNT];
    logic [7:0]         hi_b    [PLANE_COUNT];
    logic [7:0]         new_lo  [PLANE_COUNT];
    logic [7:0]         new_hi  [PLANE_COUNT];
    logic [7:0]         wd_even [PLANE_COUNT];
    logic [7:0]         wd_odd  [PLANE_COUNT];
    logic [PLANE_COUNT-1:0] wen;
    logic [PLANE_COUNT-1:0] we_even;
    logic [PLANE_COUNT-1:0] we_odd;
    logic [7:0]         cmp_lo;
    logic [7:0]         cmp_hi;
    logic               is_write;
    logic               de_even;
    logic               de_odd;
    logic [DATA_W-1:0]  rd_data;

    logic [SHOWN_W-1:0] r_dirty_even [HALF_DEPTH];
    logic [SHOWN_W-1:0] r_dirty_odd  [HALF_DEPTH];

    assign pg_in        = (PAGE_COUNT == 2) ? i_page : 1'b0;
    assign off0_in      = OFF_W'({1'b0, i_offset});
    assign half0_in     = off0_in[OFF_W-1:1];
    assign even_half_in = off0_in[0] ? t_half_addr'(half0_in + 1'b1) : half0_in;
    assign rd_addr_even = bank_addr(pg_in, even_half_in);
    assign rd_addr_odd  = bank_addr(pg_in, half0_in);
    assign wr_addr_even = bank_addr(r_pg, r_even_half);
    assign wr_addr_odd  = bank_addr(r_pg, r_odd_half);

    assign o_status.clear_last = &r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask     <= '0;
            r_shown    <= '0;
            r_clr_addr <= '0;
            for (int p = 0; p < PLANE_COUNT; p++) begin
                r_tile[p] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_MASK:   r_mask    <= i_cfg_data[MASK_W-1:0];
                    CFG_TILE_B: r_tile[0] <= i_cfg_data;
                    CFG_TILE_R: r_tile[1] <= i_cfg_data;
                    CFG_TILE_G: r_tile[2] <= i_cfg_data;
                    CFG_TILE_E: r_tile[3] <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.fire) begin
                r_shown <= n_shown;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op        <= i_operation;
            r_wide      <= i_word_access;
            r_pg        <= pg_in;
            r_plane     <= i_plane;
            r_par       <= off0_in[0];
            r_even_half <= even_half_in;
            r_odd_half  <= half0_in;
            r_data      <= i_write_data;
        end
        if (i_cmd.fire) begin
            o_read_data      <= rd_data;
            o_graphics_shown <= n_shown;
        end
    end

    for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
        logic [7:0] r_mem_even [BANK_DEPTH];
        logic [7:0] r_mem_odd  [BANK_DEPTH];
        logic [7:0] r_q_even;
        logic [7:0] r_q_odd;

        always_ff @(posedge i_clk) begin
            if (i_cmd.accept) begin
                r_q_even <= r_mem_even[rd_addr_even];
            end
            if (we_even[p]) begin
                r_mem_even[wr_addr_even] <= wd_even[p];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.accept) begin
                r_q_odd <= r_mem_odd[rd_addr_odd];
            end
            if (we_odd[p]) begin
                r_mem_odd[wr_addr_odd] <= wd_odd[p];
            end
        end

        assign rd_even[p] = r_q_even;
        assign rd_odd[p]  = r_q_odd;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_dirty_even[r_clr_addr] <= '0;
            r_dirty_odd[r_clr_addr]  <= '0;
        end else begin
            if (de_even) begin
                r_dirty_even[r_even_half][r_pg] <= 1'b1;
            end
            if (de_odd) begin
                r_dirty_odd[r_odd_half][r_pg] <= 1'b1;
            end
        end
    end

    always_comb begin
        cmp_lo   = '0;
        cmp_hi   = '0;
        is_write = 1'b0;
        for (int p = 0; p < PLANE_COUNT; p++) begin
            lo_b[p]   = r_par ? rd_odd[p] : rd_even[p];
            hi_b[p]   = r_par ? rd_even[p] : rd_odd[p];
            wen[p]    = 1'b0;
            new_lo[p] = r_tile[p];
            new_hi[p] = r_tile[p];
            if (!r_mask[p]) begin
                cmp_lo = cmp_lo | (lo_b[p] ^ r_tile[p]);
                cmp_hi = cmp_hi | (hi_b[p] ^ r_tile[p]);
            end
            case (r_op)
                OP_WRITE: begin
                    wen[p]    = (r_plane == 2'(p));
                    new_lo[p] = r_data[7:0];
                    new_hi[p] = r_data[15:8];
                end
                OP_RMW: begin
                    wen[p]    = !r_mask[p];
                    new_lo[p] = (lo_b[p] & ~r_data[7:0]) | (r_data[7:0] & r_tile[p]);
                    new_hi[p] = (hi_b[p] & ~r_data[15:8]) | (r_data[15:8] & r_tile[p]);
                end
                OP_TILE_WRITE: begin
                    wen[p] = !r_mask[p];
                end
                default: begin
                end
            endcase
            we_even[p] = i_cmd.fire & wen[p] & (r_par ? r_wide : 1'b1);
            we_odd[p]  = i_cmd.fire & wen[p] & (r_par ? 1'b1 : r_wide);
            wd_even[p] = r_par ? new_hi[p] : new_lo[p];
            wd_odd[p]  = r_par ? new_lo[p] : new_hi[p];
        end

        case (r_op)
            OP_READ: begin
                rd_data = {(r_wide ? hi_b[r_plane] : 8'h00), lo_b[r_plane]};
            end
            OP_CMP_READ: begin
                rd_data = {(r_wide ? ~cmp_hi : 8'h00), ~cmp_lo};
            end
            OP_WRITE, OP_RMW, OP_TILE_WRITE: begin
                rd_data  = '0;
                is_write = 1'b1;
            end
            default: begin
                rd_data = '0;
            end
        endcase

        de_even = i_cmd.fire & is_write & (r_par ? r_wide : 1'b1);
        de_odd  = i_cmd.fire & is_write & (r_par ? 1'b1 : r_wide);
        n_shown = r_shown | (is_write ? (SHOWN_W'(1) << r_pg) : '0);
    end

endmodule

// File: sv/planar_vram_tile_raster_unit_top.sv
// Flow: an accepted item is captured and its plane banks are read; in ST_EXEC its
// result is registered, which is held back while the output is stalled.
// Input is stalled while an item is executing; the plane banks are read on the
// accept edge and written when the item fires, one port pair per bank.
// Reset: synchronous, active low; afterwards a pass over the PLANE_BYTES / 2
// dirty-mark entries clears them, and input is stalled until it is done.
// ----------------------------------------------------------------------------
// planar_vram_tile_raster_unit_top
// Four-plane, two-page graphics memory with a tile raster unit in front.
// ----------------------------------------------------------------------------
`include "planar_vram_tile_raster_unit_top_assert.svh"

module planar_vram_tile_raster_unit_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic [pvtru_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [pvtru_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [pvtru_pkg::OP_W-1:0]            i_operation,
    input  logic                                  i_word_access,
    input  logic                                  i_page,
    input  logic [1:0]                            i_plane,
    input  logic [pvtru_pkg::OFFSET_W-1:0]        i_offset,
    input  logic [pvtru_pkg::DATA_W-1:0]          i_write_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [pvtru_pkg::DATA_W-1:0]          o_read_data,
    output logic [pvtru_pkg::SHOWN_W-1:0]         o_graphics_shown
);
    import pvtru_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    pvtru_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    pvtru_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_operation      (i_operation),
        .i_word_access    (i_word_access),
        .i_page           (i_page),
        .i_plane          (i_plane),
        .i_offset         (i_offset),
        .i_write_data     (i_write_data),
        .o_read_data      (o_read_data),
        .o_graphics_shown (o_graphics_shown)
    );

    `PVTRU_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    `PVTRU_ASSERT_NOW(a_clear_after_reset, i_clk, i_rst_n, !$past(i_rst_n), o_in_stall)
    `PVTRU_ASSERT_NOW(a_result_after_work, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall))

endmodule

// File: sim/vram_access_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// VRAM access checker
// Watches the register port and both item channels of the tile raster unit.
// Every accepted access is run through a shadow of the four planes, the tile
// registers and the shown flags, and the result it should produce is queued.
// Results leaving the block are compared in order, field by field.
// ----------------------------------------------------------------------------
module vram_access_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [pvtru_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pvtru_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                             i_in_valid,
    input  logic                             i_in_stall,
    input  logic [pvtru_pkg::OP_W-1:0]       i_operation,
    input  logic                             i_word_access,
    input  logic                             i_page,
    input  logic [1:0]                       i_plane,
    input  logic [pvtru_pkg::OFFSET_W-1:0]   i_offset,
    input  logic [pvtru_pkg::DATA_W-1:0]     i_write_data,
    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  logic [pvtru_pkg::DATA_W-1:0]     i_read_data,
    input  logic [pvtru_pkg::SHOWN_W-1:0]    i_graphics_shown,
    output int                               o_fail_count,
    output int                               o_pending
);
    import pvtru_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0]  read_data;
        logic [SHOWN_W-1:0] shown;
    } t_result;

    bit [7:0]           plane_shadow [PAGE_COUNT][PLANE_COUNT][PLANE_BYTES];
    logic [MASK_W-1:0]  planes_off = '0;
    logic [7:0]         tile_byte [PLANE_COUNT];
    logic [SHOWN_W-1:0] shown_flags = '0;
    t_result            expected_results [$];
    int                 fail_total = 0;

    function automatic logic [7:0] compare_lane(input logic pg,
                                                input logic [OFFSET_W-1:0] off);
        logic [7:0] diff;
        diff = '0;
        for (int p = 0; p < PLANE_COUNT; p++) begin
            if (!planes_off[p]) begin
                diff |= plane_shadow[pg][p][off] ^ tile_byte[p];
            end
        end
        return ~diff;
    endfunction

    function automatic void tile_lane(input logic direct, input logic pg,
                                      input logic [OFFSET_W-1:0] off,
                                      input logic [7:0] pixels);
        shown_flags[pg] = 1'b1;
        for (int p = 0; p < PLANE_COUNT; p++) begin
            if (!planes_off[p]) begin
                if (direct) begin
                    plane_shadow[pg][p][off] = tile_byte[p];
                end else begin
                    plane_shadow[pg][p][off] = (plane_shadow[pg][p][off] & ~pixels) |
                                               (pixels & tile_byte[p]);
                end
            end
        end
    endfunction

    function automatic t_result predict_access(input logic [OP_W-1:0] op,
                                               input logic wide, input logic pg,
                                               input logic [1:0] pl,
                                               input logic [OFFSET_W-1:0] off_lo,
                                               input logic [DATA_W-1:0] data);
        t_result             r;
        logic [OFFSET_W-1:0] off_hi;
        r.read_data = '0;
        off_hi = off_lo + 1'b1;
        case (op)
            OP_READ: begin
                r.read_data[7:0] = plane_shadow[pg][pl][off_lo];
                if (wide) begin
                    r.read_data[15:8] = plane_shadow[pg][pl][off_hi];
                end
            end
            OP_WRITE: begin
                plane_shadow[pg][pl][off_lo] = data[7:0];
                shown_flags[pg] = 1'b1;
                if (wide) begin
                    plane_shadow[pg][pl][off_hi] = data[15:8];
                end
            end
            OP_CMP_READ: begin
                r.read_data[7:0] = compare_lane(pg, off_lo);
                if (wide) begin
                    r.read_data[15:8] = compare_lane(pg, off_hi);
                end
            end
            OP_RMW, OP_TILE_WRITE: begin
                tile_lane(op == OP_TILE_WRITE, pg, off_lo, data[7:0]);
                if (wide) begin
                    tile_lane(op == OP_TILE_WRITE, pg, off_hi, data[15:8]);
                end
            end
            default: begin
            end
        endcase
        r.shown = shown_flags;
        return r;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_result want;
        if (!i_rst_n) begin
            planes_off = '0;
            shown_flags = '0;
            for (int p = 0; p < PLANE_COUNT; p++) begin
                tile_byte[p] = '0;
            end
            expected_results.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_MASK: begin
                        planes_off = i_cfg_data[MASK_W-1:0];
                    end
                    CFG_TILE_B, CFG_TILE_R, CFG_TILE_G, CFG_TILE_E: begin
                        tile_byte[2'(i_cfg_index - CFG_TILE_B)] = i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result with no item outstanding: read_data %h graphics_shown %b",
                           i_read_data, i_graphics_shown);
                    fail_total++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_read_data !== want.read_data) begin
                        $error("read_data: expected %h, got %h", want.read_data, i_read_data);
                        fail_total++;
                    end
                    if (i_graphics_shown !== want.shown) begin
                        $error("graphics_shown: expected %b, got %b",
                               want.shown, i_graphics_shown);
                        fail_total++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_results.push_back(predict_access(i_operation, i_word_access,
                                                          i_page, i_plane, i_offset,
                                                          i_write_data));
            end
        end
        o_pending <= expected_results.size();
        o_fail_count <= fail_total;
    end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Planar VRAM tile raster unit testbench
// Drives plain, tile-compare, read-modify-write and tile-direct accesses with
// random gaps and output stalls through several tile and plane-mask settings.
// Reads only touch bytes that have been written before. A checker module
// predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    import pvtru_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 11;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 50;
    localparam int MAX_PAUSE    = 16;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 4;
    localparam int STALL_LIMIT  = 60000;
    localparam int POOL_SPAN    = 16;

    localparam logic [1:0] PLANE_B = 2'd0;
    localparam logic [1:0] PLANE_R = 2'd1;
    localparam logic [1:0] PLANE_G = 2'd2;
    localparam logic [1:0] PLANE_E = 2'd3;

    localparam logic [OP_W-1:0]     OP_TOP         = '1;
    localparam logic [MASK_W-1:0]   ALL_PLANES_ON  = '0;
    localparam logic [MASK_W-1:0]   ALL_PLANES_OFF = '1;
    localparam logic [OFFSET_W-1:0] LAST_OFF       = '1;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic                wide;
        logic                pg;
        logic [1:0]          pl;
        logic [OFFSET_W-1:0] off;
        logic [DATA_W-1:0]   data;
    } t_access;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic [OP_W-1:0]       i_operation = '0;
    logic                  i_word_access = 1'b0;
    logic                  i_page = 1'b0;
    logic [1:0]            i_plane = '0;
    logic [OFFSET_W-1:0]   i_offset = '0;
    logic [DATA_W-1:0]     i_write_data = '0;
    logic                  i_out_stall = 1'b0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [DATA_W-1:0]     o_read_data;
    logic [SHOWN_W-1:0]    o_graphics_shown;

    bit                  written [PAGE_COUNT][PLANE_COUNT][PLANE_BYTES];
    logic [MASK_W-1:0]   planes_off = '0;
    logic [OFFSET_W-1:0] mid_base;
    int                  send_max_pause = 0;
    int                  recv_max_pause = 0;
    bit                  hold_request = 1'b0;
    int                  fail_count;
    int                  pending;
    int                  idle_cycles = 0;

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    planar_vram_tile_raster_unit_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_operation      (i_operation),
        .i_word_access    (i_word_access),
        .i_page           (i_page),
        .i_plane          (i_plane),
        .i_offset         (i_offset),
        .i_write_data     (i_write_data),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_read_data      (o_read_data),
        .o_graphics_shown (o_graphics_shown)
    );

    vram_access_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_operation      (i_operation),
        .i_word_access    (i_word_access),
        .i_page           (i_page),
        .i_plane          (i_plane),
        .i_offset         (i_offset),
        .i_write_data     (i_write_data),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_read_data      (o_read_data),
        .i_graphics_shown (o_graphics_shown),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin : result_sink
        int unsigned pause;
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                pause = $urandom_range(recv_max_pause, 0);
                if (pause != 0) begin
                    i_out_stall <= 1'b1;
                    repeat (pause) @(posedge i_clk);
                end
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
        end
    end

    function automatic bit reads_written(input t_access a);
        logic [OFFSET_W-1:0] lane_off;
        bit                  ok;
        ok = 1'b1;
        for (int lane = 0; lane <= int'(a.wide); lane++) begin
            lane_off = a.off + OFFSET_W'(lane);
            if (a.op == OP_READ) begin
                ok &= written[a.pg][a.pl][lane_off];
            end else if (a.op == OP_CMP_READ || a.op == OP_RMW) begin
                for (int p = 0; p < PLANE_COUNT; p++) begin
                    if (!planes_off[p]) begin
                        ok &= written[a.pg][p][lane_off];
                    end
                end
            end
        end
        return ok;
    endfunction

    function automatic void note_writes(input t_access a);
        logic [OFFSET_W-1:0] lane_off;
        for (int lane = 0; lane <= int'(a.wide); lane++) begin
            lane_off = a.off + OFFSET_W'(lane);
            if (a.op == OP_WRITE) begin
                written[a.pg][a.pl][lane_off] = 1'b1;
            end else if (a.op == OP_TILE_WRITE) begin
                for (int p = 0; p < PLANE_COUNT; p++) begin
                    if (!planes_off[p]) begin
                        written[a.pg][p][lane_off] = 1'b1;
                    end
                end
            end
        end
    endfunction

    function automatic t_access random_access();
        t_access     a;
        int unsigned pick;
        if ($urandom_range(19, 0) == 0) begin
            a.op = OP_W'($urandom_range(OP_TOP, OP_TILE_WRITE + 1));
        end else begin
            a.op = OP_W'($urandom_range(OP_TILE_WRITE, OP_READ));
        end
        a.wide = 1'($urandom_range(1, 0));
        a.pg = 1'($urandom_range(1, 0));
        a.pl = 2'($urandom_range(PLANE_E, PLANE_B));
        pick = $urandom_range(9, 0);
        if (pick < 3) begin
            a.off = OFFSET_W'($urandom);
        end else if (pick < 5) begin
            a.off = OFFSET_W'($urandom_range(POOL_SPAN / 2 - 1, 0));
        end else if (pick < 7) begin
            a.off = LAST_OFF - OFFSET_W'($urandom_range(POOL_SPAN / 2 - 1, 0));
        end else begin
            a.off = mid_base + OFFSET_W'($urandom_range(POOL_SPAN - 1, 0));
        end
        a.data = DATA_W'($urandom);
        if ($urandom_range(7, 0) == 0) begin
            a.data = $urandom_range(1, 0) ? '1 : '0;
        end
        return a;
    endfunction

    task automatic send_access(input t_access a);
        int unsigned pause;
        pause = $urandom_range(send_max_pause, 0);
        if (pause != 0) begin
            i_in_valid <= 1'b0;
            repeat (pause) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_operation <= a.op;
        i_word_access <= a.wide;
        i_page <= a.pg;
        i_plane <= a.pl;
        i_offset <= a.off;
        i_write_data <= a.data;
        note_writes(a);
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
    endtask

    task automatic load_settings(input logic [MASK_W-1:0] mask, input logic [7:0] blue,
                                 input logic [7:0] red, input logic [7:0] green,
                                 input logic [7:0] extra);
        write_reg(CFG_MASK, CFG_DATA_W'(mask));
        write_reg(CFG_TILE_B, blue);
        write_reg(CFG_TILE_R, red);
        write_reg(CFG_TILE_G, green);
        write_reg(CFG_TILE_E, extra);
        i_cfg_wr_en <= 1'b0;
        planes_off = mask;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        t_access a;
        mid_base = OFFSET_W'($urandom_range(PLANE_BYTES - POOL_SPAN - 64, 64));
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);

        load_settings(ALL_PLANES_ON, 8'h00, 8'hFF, 8'hA5, 8'h5A);
        send_access('{OP_TILE_WRITE, 1'b1, 1'b0, PLANE_B, LAST_OFF, 16'hFFFF});
        send_access('{OP_TILE_WRITE, 1'b1, 1'b1, PLANE_B, LAST_OFF, 16'h0000});
        send_access('{OP_READ, 1'b1, 1'b0, PLANE_G, LAST_OFF, 16'h0000});
        send_access('{OP_CMP_READ, 1'b1, 1'b0, PLANE_B, LAST_OFF, 16'h0000});
        send_access('{OP_WRITE, 1'b0, 1'b0, PLANE_B, 15'd0, 16'hFFFF});
        send_access('{OP_CMP_READ, 1'b1, 1'b0, PLANE_B, LAST_OFF, 16'hFFFF});
        send_access('{OP_WRITE, 1'b1, 1'b1, PLANE_E, LAST_OFF, 16'h1234});
        send_access('{OP_READ, 1'b1, 1'b1, PLANE_E, LAST_OFF, 16'h0000});
        send_access('{OP_RMW, 1'b1, 1'b0, PLANE_B, LAST_OFF, 16'hF00F});
        send_access('{OP_READ, 1'b1, 1'b0, PLANE_B, LAST_OFF, 16'h0000});
        send_access('{OP_READ, 1'b0, 1'b0, PLANE_R, 15'd0, 16'h0000});
        send_access('{OP_TILE_WRITE + 3'd1, 1'b1, 1'b0, PLANE_E, LAST_OFF, 16'hFFFF});
        send_access('{OP_TILE_WRITE + 3'd2, 1'b0, 1'b1, PLANE_R, 15'd0, 16'h5555});
        send_access('{OP_TOP, 1'b1, 1'b1, PLANE_G, LAST_OFF, 16'hAAAA});
        send_access('{OP_RMW, 1'b0, 1'b1, PLANE_B, 15'd0, 16'h0000});
        send_access('{OP_RMW, 1'b1, 1'b1, PLANE_B, LAST_OFF, 16'hFFFF});
        send_access('{OP_CMP_READ, 1'b1, 1'b1, PLANE_B, LAST_OFF, 16'h0000});

        wait_idle();
        load_settings(ALL_PLANES_OFF, 8'hFF, 8'h00, 8'hFF, 8'h00);
        send_access('{OP_CMP_READ, 1'b1, 1'b0, PLANE_B, LAST_OFF, 16'h0000});
        send_access('{OP_TILE_WRITE, 1'b1, 1'b0, PLANE_B, LAST_OFF, 16'h0000});
        send_access('{OP_RMW, 1'b0, 1'b1, PLANE_B, LAST_OFF, 16'hFFFF});
        send_access('{OP_READ, 1'b1, 1'b0, PLANE_G, LAST_OFF, 16'h0000});
        send_access('{OP_WRITE, 1'b1, 1'b0, PLANE_R, LAST_OFF, 16'h00FF});
        send_access('{OP_READ, 1'b1, 1'b0, PLANE_R, LAST_OFF, 16'h0000});

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            case (ph)
                0: begin
                    load_settings(ALL_PLANES_ON, 8'($urandom), 8'($urandom),
                                  8'($urandom), 8'($urandom));
                    send_max_pause = MAX_PAUSE;
                    recv_max_pause = MAX_PAUSE;
                end
                1: begin
                    load_settings(ALL_PLANES_OFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
                    send_max_pause = 0;
                    recv_max_pause = 0;
                end
                2: begin
                    load_settings(MASK_W'($urandom), 8'h00, 8'h00, 8'h00, 8'h00);
                    send_max_pause = 0;
                    recv_max_pause = MAX_PAUSE;
                    hold_request = 1'b1;
                end
                default: begin
                    load_settings(MASK_W'($urandom), 8'($urandom), 8'($urandom),
                                  8'($urandom), 8'($urandom));
                    send_max_pause = $urandom_range(1, 0) * MAX_PAUSE;
                    recv_max_pause = $urandom_range(1, 0) * MAX_PAUSE;
                end
            endcase
            repeat (PHASE_ITEMS) begin
                a = random_access();
                if (!reads_written(a)) begin
                    a.op = (planes_off == ALL_PLANES_ON) ? OP_TILE_WRITE : OP_WRITE;
                end
                send_access(a);
            end
        end

        wait_idle();
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+sv
sv/pvtru_pkg.sv
sv/pvtru_ctrl.sv
sv/pvtru_datapath.sv
sv/planar_vram_tile_raster_unit_top.sv
sim/vram_access_checker.sv
sim/testbench.sv
